>>> hw/rtl/csp_pkg.sv
`default_nettype none

package csp_pkg;

    // Default depth of the cap store
    localparam int MAX_CAPS_DEF = 128;

    localparam int ID_W     = 63;
    localparam int POS_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;

    // Run status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ODD  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROP = 2'd2;

    // One stored cap
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [POS_W-1:0]    pos;
        logic                side;
        logic [HANDLE_W-1:0] handle;
    } cap_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_EM_RDL,
        ST_EM_RDR,
        ST_EM_OUT
    } csp_state_t;

    // True if cap a sorts strictly before cap b (side 1 before side 0)
    function automatic logic cap_before(input cap_t a, input cap_t b);
        logic [ID_W+POS_W:0] ka;
        logic [ID_W+POS_W:0] kb;
        ka = {a.id, a.pos, ~a.side};
        kb = {b.id, b.pos, ~b.side};
        return ka < kb;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cap_sort_and_pair.sv
`default_nettype none

// Channel  | handshake              | payload
// ---------+------------------------+---------------------------------------------
// input    | in_valid / in_stall    | seq_id, position, side_bit, handle, final_cap
// output   | out_valid / out_stall  | left_handle, right_handle, pair_valid,
//          |                        | status, last_pair
//
// A cap goes straight into an empty store; otherwise the sequencer reads the
// top stored cap and walks down, shifting up each stored cap with a larger key,
// through the single read port of the cap store.
// After the final cap each result waits in EM_RDL for the output register to
// drain, takes one store read per handle and is loaded in EM_OUT.
// Reset clears the count, the overflow flag and the sequencer; store contents
// are not cleared. Input is stalled whenever the sequencer is not idle; a
// stalled output holds its result and pauses the pair walk.
module cap_sort_and_pair
#(
    parameter int MAX_CAPS = csp_pkg::MAX_CAPS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [csp_pkg::ID_W-1:0]      seq_id,
    input  wire logic [csp_pkg::POS_W-1:0]     position,
    input  wire logic                          side_bit,
    input  wire logic [csp_pkg::HANDLE_W-1:0]  handle,
    input  wire logic                          final_cap,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [csp_pkg::HANDLE_W-1:0]       left_handle,
    output logic [csp_pkg::HANDLE_W-1:0]       right_handle,
    output logic                               pair_valid,
    output logic [csp_pkg::STATUS_W-1:0]       status,
    output logic                               last_pair
);
    import csp_pkg::*;

    localparam int ADDR_W = (MAX_CAPS > 1) ? $clog2(MAX_CAPS) : 1;
    localparam int CNT_W  = $clog2(MAX_CAPS + 1);

    cap_t mem [MAX_CAPS];
    cap_t rd_data_reg;

    csp_state_t state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0]  e_reg, e_next;
    cap_t              new_reg;
    logic              final_reg;
    logic [HANDLE_W-1:0] left_reg;

    logic              rd_en, wr_en, load_out;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    cap_t              wr_data, in_cap;
    logic [CNT_W:0]    e_p1, e_p2;
    logic              single, last_res, full;
    logic [STATUS_W-1:0] run_status;

    assign in_cap   = '{id: seq_id, pos: position, side: side_bit, handle: handle};
    assign full     = ({1'b0, count_reg} >= (CNT_W+1)'(MAX_CAPS));
    assign e_p1     = {1'b0, e_reg} + (CNT_W+1)'(1);
    assign e_p2     = {1'b0, e_reg} + (CNT_W+1)'(2);
    assign single   = (e_p1 == {1'b0, count_reg});
    assign last_res = single || (e_p2 == {1'b0, count_reg});
    assign run_status = ovf_reg ? STATUS_DROP : (count_reg[0] ? STATUS_ODD : STATUS_OK);
    assign in_stall = (state_reg != ST_IDLE);

    // Cap store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Sequencer: next state and store accesses
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        k_next     = k_reg;
        e_next     = e_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = new_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                e_next = '0;
                if (in_valid)
                begin
                    if (full)
                    begin
                        ovf_next   = 1'b1;
                        state_next = final_cap ? ST_EM_RDL : ST_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_data    = in_cap;
                        count_next = count_reg + CNT_W'(1);
                        state_next = final_cap ? ST_EM_RDL : ST_IDLE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ADDR_W'(count_reg - CNT_W'(1));
                        k_next     = rd_addr;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                wr_en   = 1'b1;
                wr_addr = k_reg + ADDR_W'(1);
                if (cap_before(new_reg, rd_data_reg))
                begin
                    // shift the stored cap up one place and walk down
                    wr_data = rd_data_reg;
                    if (k_reg == '0)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        rd_en  = 1'b1;
                        rd_addr = k_reg - ADDR_W'(1);
                        k_next = rd_addr;
                    end
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = final_reg ? ST_EM_RDL : ST_IDLE;
                end
            end
            ST_PLACE:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = final_reg ? ST_EM_RDL : ST_IDLE;
            end
            ST_EM_RDL:
            begin
                // wait for the output register to drain
                if (!out_valid)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = e_reg[ADDR_W-1:0];
                    state_next = ST_EM_RDR;
                end
            end
            ST_EM_RDR:
            begin
                if (!single)
                begin
                    rd_en   = 1'b1;
                    rd_addr = e_p1[ADDR_W-1:0];
                end
                state_next = ST_EM_OUT;
            end
            ST_EM_OUT:
            begin
                load_out = 1'b1;
                e_next   = e_p2[CNT_W-1:0];
                if (last_res)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EM_RDL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (load_out)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        e_reg <= e_next;
        if (state_reg == ST_IDLE && in_valid)
        begin
            new_reg   <= in_cap;
            final_reg <= final_cap;
        end
        if (state_reg == ST_EM_RDR)
        begin
            left_reg <= rd_data_reg.handle;
        end
        if (load_out)
        begin
            left_handle  <= left_reg;
            right_handle <= single ? '0 : rd_data_reg.handle;
            pair_valid   <= !single;
            status       <= run_status;
            last_pair    <= last_res;
        end
    end

    // Store never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} <= (CNT_W+1)'(MAX_CAPS)))
        else $error("cap count beyond store depth");

    // Finishing a run empties the store
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EM_OUT && last_res) |=> (count_reg == '0 && !ovf_reg))
        else $error("store not cleared after run");

    // A status-only result is always the last of its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pair_valid) |-> last_pair)
        else $error("unpaired result not last");

    // Output is loaded only when free
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !out_valid)
        else $error("result overwritten");

endmodule

`default_nettype wire

>>> tb/sv/tb_cap_sort_and_pair.sv
`default_nettype none

module tb_cap_sort_and_pair;
    timeunit 1ns;
    timeprecision 1ps;

    import csp_pkg::*;

    localparam int STORE_DEPTH = MAX_CAPS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [ID_W-1:0]  ID_MAX  = {ID_W{1'b1}};
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    typedef struct {
        logic [ID_W-1:0]     id;
        logic [POS_W-1:0]    pos;
        logic                side;
        logic [HANDLE_W-1:0] hdl;
        logic                fin;
    } cap_item_t;

    typedef struct {
        logic [HANDLE_W-1:0] lh;
        logic [HANDLE_W-1:0] rh;
        logic                pv;
        logic [STATUS_W-1:0] st;
        logic                lp;
    } pair_res_t;

    // Directed row: a cap, and for single-result runs the result typed in
    typedef struct {
        cap_item_t cap;
        bit        typed;
        pair_res_t res;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [ID_W-1:0]     seq_id;
    logic [POS_W-1:0]    position;
    logic                side_bit;
    logic [HANDLE_W-1:0] handle;
    logic                final_cap;
    logic                out_valid;
    logic                out_stall;
    logic [HANDLE_W-1:0] left_handle;
    logic [HANDLE_W-1:0] right_handle;
    logic                pair_valid;
    logic [STATUS_W-1:0] status;
    logic                last_pair;

    cap_item_t sorted_caps[$];
    bit        caps_dropped;
    pair_res_t pending_pairs[$];
    int        err_count;
    int        cycle_count;
    int        sender_idle_pct;
    int        recv_idle_pct;
    int        hold_left;

    cap_sort_and_pair u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .seq_id       (seq_id),
        .position     (position),
        .side_bit     (side_bit),
        .handle       (handle),
        .final_cap    (final_cap),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_handle  (left_handle),
        .right_handle (right_handle),
        .pair_valid   (pair_valid),
        .status       (status),
        .last_pair    (last_pair)
    );

    // Clock and cycle limit
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [HANDLE_W-1:0] got,
                                   input logic [HANDLE_W-1:0] want);
        $display("MISMATCH %s: got %h, want %h at cycle %0d", what, got, want, cycle_count);
        err_count++;
    endtask

    // True if cap a sorts strictly ahead of cap b
    function automatic bit sorts_ahead(input cap_item_t a, input cap_item_t b);
        if (a.id != b.id)
            return a.id < b.id;
        if (a.pos != b.pos)
            return a.pos < b.pos;
        return a.side && !b.side;
    endfunction

    // Insert the cap after all equal-or-smaller keys; on the final cap emit pairs
    function automatic void absorb_cap(input cap_item_t c);
        int        at;
        int        npairs;
        bit        odd;
        logic [STATUS_W-1:0] st;
        pair_res_t r;
        at = 0;
        if (sorted_caps.size() >= STORE_DEPTH)
            caps_dropped = 1'b1;
        else
        begin
            while (at < sorted_caps.size() && !sorts_ahead(c, sorted_caps[at]))
                at++;
            sorted_caps.insert(at, c);
        end
        if (c.fin)
        begin
            odd = 1'(sorted_caps.size() % 2);
            st = caps_dropped ? STATUS_DROP : (odd ? STATUS_ODD : STATUS_OK);
            npairs = sorted_caps.size() / 2;
            for (int p = 0; p < npairs; p++)
            begin
                r.lh = sorted_caps[2*p].hdl;
                r.rh = sorted_caps[2*p+1].hdl;
                r.pv = 1'b1;
                r.st = st;
                r.lp = !odd && (p + 1 == npairs);
                pending_pairs.push_back(r);
            end
            if (odd)
            begin
                r.lh = sorted_caps[sorted_caps.size()-1].hdl;
                r.rh = '0;
                r.pv = 1'b0;
                r.st = st;
                r.lp = 1'b1;
                pending_pairs.push_back(r);
            end
            sorted_caps.delete();
            caps_dropped = 1'b0;
        end
    endfunction

    // Offer one cap, idling first at the sender's rate, and hold until taken
    task automatic offer_cap(input cap_item_t c);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        seq_id    <= c.id;
        position  <= c.pos;
        side_bit  <= c.side;
        handle    <= c.hdl;
        final_cap <= c.fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        absorb_cap(c);
    endtask

    function automatic cap_item_t random_cap(input bit fin);
        cap_item_t c;
        case ($urandom_range(3))
            0: c.id = '0;
            1: c.id = ID_MAX;
            2: c.id = ID_W'($urandom_range(3));
            default: c.id = ID_W'({$urandom, $urandom});
        endcase
        case ($urandom_range(3))
            0: c.pos = '0;
            1: c.pos = POS_MAX;
            2: c.pos = POS_W'($urandom_range(7));
            default: c.pos = $urandom;
        endcase
        c.side = 1'($urandom_range(1));
        c.hdl  = $urandom;
        c.fin  = fin;
        return c;
    endfunction

    task automatic send_run(input int ncaps);
        for (int k = 0; k < ncaps; k++)
            offer_cap(random_cap(k == ncaps - 1));
    endtask

    // Receiver: check each taken result, then choose the next stall
    initial
    begin
        pair_res_t w;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_pairs.size() == 0)
                begin
                    $display("MISMATCH unexpected result at cycle %0d", cycle_count);
                    err_count++;
                end
                else
                begin
                    w = pending_pairs.pop_front();
                    if (left_handle !== w.lh)
                        report_mismatch("left_handle", left_handle, w.lh);
                    if (right_handle !== w.rh)
                        report_mismatch("right_handle", right_handle, w.rh);
                    if (pair_valid !== w.pv)
                        report_mismatch("pair_valid", pair_valid, w.pv);
                    if (status !== w.st)
                        report_mismatch("status", status, w.st);
                    if (last_pair !== w.lp)
                        report_mismatch("last_pair", last_pair, w.lp);
                end
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Stimulus
    initial
    begin
        dir_row_t dir_rows[] = '{
            '{'{ID_MAX, POS_MAX, 1'b1, 32'hFFFF_FFFF, 1'b1}, 1'b1,
              '{32'hFFFF_FFFF, 32'h0, 1'b0, STATUS_ODD, 1'b1}},
            '{'{63'd0, 32'd0, 1'b0, 32'h1, 1'b0}, 1'b0, '{0, 0, 0, STATUS_OK, 0}},
            '{'{63'd0, 32'd0, 1'b1, 32'h2, 1'b1}, 1'b1,
              '{32'h2, 32'h1, 1'b1, STATUS_OK, 1'b1}},
            '{'{63'd5, 32'd7, 1'b0, 32'hA, 1'b0}, 1'b0, '{0, 0, 0, STATUS_OK, 0}},
            '{'{63'd5, 32'd7, 1'b0, 32'hB, 1'b1}, 1'b1,
              '{32'hA, 32'hB, 1'b1, STATUS_OK, 1'b1}},
            '{'{ID_MAX, 32'd0, 1'b0, 32'h10, 1'b0}, 1'b0, '{0, 0, 0, STATUS_OK, 0}},
            '{'{63'd0, POS_MAX, 1'b0, 32'h11, 1'b0}, 1'b0, '{0, 0, 0, STATUS_OK, 0}},
            '{'{63'd0, POS_MAX, 1'b1, 32'h12, 1'b0}, 1'b0, '{0, 0, 0, STATUS_OK, 0}},
            '{'{63'd1, 32'd5, 1'b1, 32'h13, 1'b0}, 1'b0, '{0, 0, 0, STATUS_OK, 0}},
            '{'{63'd0, 32'd0, 1'b0, 32'h14, 1'b1}, 1'b0, '{0, 0, 0, STATUS_OK, 0}},
            '{'{63'd3, 32'd100, 1'b0, 32'h20, 1'b0}, 1'b0, '{0, 0, 0, STATUS_OK, 0}},
            '{'{63'd3, 32'd99, 1'b1, 32'h21, 1'b0}, 1'b0, '{0, 0, 0, STATUS_OK, 0}},
            '{'{63'd3, 32'd100, 1'b1, 32'h22, 1'b0}, 1'b0, '{0, 0, 0, STATUS_OK, 0}},
            '{'{63'd2, POS_MAX, 1'b0, 32'h23, 1'b0}, 1'b0, '{0, 0, 0, STATUS_OK, 0}},
            '{'{63'd3, 32'd0, 1'b0, 32'h24, 1'b0}, 1'b0, '{0, 0, 0, STATUS_OK, 0}},
            '{'{63'd3, 32'd100, 1'b0, 32'h25, 1'b1}, 1'b0, '{0, 0, 0, STATUS_OK, 0}}
        };

        // Hold every input at a known value and apply reset
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        seq_id          <= '0;
        position        <= '0;
        side_bit        <= 1'b0;
        handle          <= '0;
        final_cap       <= 1'b0;
        err_count       = 0;
        cycle_count     = 0;
        hold_left       = 0;
        caps_dropped    = 1'b0;
        sender_idle_pct = 21;
        recv_idle_pct   = 84;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed rows; typed rows replace the predicted result
        foreach (dir_rows[i])
        begin
            offer_cap(dir_rows[i].cap);
            if (dir_rows[i].typed)
            begin
                void'(pending_pairs.pop_back());
                pending_pairs.push_back(dir_rows[i].res);
            end
        end

        // Random runs under three idling mixes
        for (int ph = 0; ph < 3; ph++)
        begin
            sender_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 84 : 0;
            recv_idle_pct   = (ph == 0) ? 84 : (ph == 1) ? 21 : 0;
            for (int r = 0; r < 11; r++)
                send_run($urandom_range(9) < 7 ? $urandom_range(1, 6) : $urandom_range(7, 16));
            // pause the sender until every result is in
            in_valid <= 1'b0;
            wait (pending_pairs.size() == 0);
        end

        // Long receiver hold-off while runs keep arriving
        hold_left = 700;
        send_run(20);
        send_run(3);
        send_run(9);

        // Overfill the store, dropping the final cap too
        send_run(STORE_DEPTH + 2);

        in_valid <= 1'b0;
        wait (pending_pairs.size() == 0);
        repeat (40) @(posedge clk);
        if (err_count == 0 && sorted_caps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/csp_pkg.sv
hw/rtl/cap_sort_and_pair.sv
tb/sv/tb_cap_sort_and_pair.sv
